>>> src/clt_pkg.sv
// Shared types, codes and helpers for the command line tokenizer.
`default_nettype none
package clt_pkg;

   localparam int MAX_ARGS = 16;
   localparam int CNT_W    = $clog2(MAX_ARGS + 1);
   localparam int IDX_W    = 5;
   localparam int REC_MAX  = 3;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_NUL   = 8'h00;

   typedef enum logic [2:0] {
      MODE_BETWEEN = 3'd0,
      MODE_PLAIN   = 3'd1,
      MODE_QUOTED  = 3'd2,
      MODE_EMBED   = 3'd3,
      MODE_DRAIN   = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_END   = 2'd1,
      KIND_DONE  = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_EMPTY    = 2'd1,
      ERR_TOO_MANY = 2'd2,
      ERR_UNTERM   = 2'd3
   } err_type;

   typedef struct packed {
      kind_type           kind;
      logic [7:0]         out_byte;
      logic [IDX_W-1:0]   arg_index;
      err_type            error_code;
      logic               message_end;
   } rec_type;

   // One group of results caused by a single input item.
   typedef struct packed {
      logic               valid;
      logic [1:0]         count;
      rec_type [REC_MAX-1:0] rec;
   } grp_type;

   function automatic logic [IDX_W-1:0] count_idx(input logic [CNT_W-1:0] c);
      logic [CNT_W+IDX_W-1:0] wide;
      wide = {{IDX_W{1'b0}}, c};
      return wide[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] token_idx(input logic [CNT_W-1:0] c);
      logic [CNT_W-1:0] t;
      t = (c == '0) ? '0 : c - 1'b1;
      return count_idx(t);
   endfunction

   function automatic rec_type make_rec(input kind_type k, input logic [7:0] b,
                                        input logic [IDX_W-1:0] idx, input err_type e,
                                        input logic fin);
      rec_type r;
      r.kind        = k;
      r.out_byte    = b;
      r.arg_index   = idx;
      r.error_code  = e;
      r.message_end = fin;
      return r;
   endfunction

endpackage
`default_nettype wire

>>> src/clt_core.sv
// Input register, scan mode and argument count, and per-byte result decode.
`default_nettype none
module clt_core (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire logic [7:0]      req_tdata,
   input  wire logic            req_tlast,
   input  wire logic            grp_ready,
   output clt_pkg::grp_type     grp
);
   import clt_pkg::*;

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             in_last_ff;
   mode_type         mode_ff, mode_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             consume;
   logic             accept;
   rec_type [REC_MAX-1:0] recs;
   logic [1:0]       n;

   assign consume    = in_valid_ff && grp_ready;
   assign req_tready = !in_valid_ff || grp_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Decode of the registered byte against the current mode.
   always_comb begin
      logic ended;
      recs    = '0;
      n       = 2'd0;
      ended   = 1'b0;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      if (mode_ff == MODE_DRAIN) begin
         if (in_last_ff) begin
            mode_in = MODE_BETWEEN;
            cnt_in  = '0;
         end
      end else begin
         if (in_byte_ff != CH_NUL) begin
            case (mode_ff)
               MODE_PLAIN: begin
                  if (in_byte_ff == CH_SPACE) begin
                     recs[n] = make_rec(KIND_END, 8'd0, token_idx(cnt_in), ERR_NONE, 1'b0);
                     n = n + 2'd1;
                     mode_in = MODE_BETWEEN;
                  end else if (in_byte_ff == CH_QUOTE) begin
                     mode_in = MODE_EMBED;
                  end else begin
                     recs[n] = make_rec(KIND_BYTE, in_byte_ff, token_idx(cnt_in),
                                        ERR_NONE, 1'b0);
                     n = n + 2'd1;
                  end
               end
               MODE_QUOTED, MODE_EMBED: begin
                  if (in_byte_ff == CH_QUOTE) begin
                     recs[n] = make_rec(KIND_END, 8'd0, token_idx(cnt_in), ERR_NONE, 1'b0);
                     n = n + 2'd1;
                     mode_in = MODE_BETWEEN;
                  end else begin
                     recs[n] = make_rec(KIND_BYTE, in_byte_ff, token_idx(cnt_in),
                                        ERR_NONE, 1'b0);
                     n = n + 2'd1;
                  end
               end
               default: begin
                  mode_in = MODE_BETWEEN;
                  if (in_byte_ff != CH_SPACE) begin
                     if (cnt_in >= CNT_W'(MAX_ARGS)) begin
                        recs[n] = make_rec(KIND_ERROR, 8'd0, '0, ERR_TOO_MANY, 1'b1);
                        n = n + 2'd1;
                        ended = 1'b1;
                     end else begin
                        cnt_in = cnt_in + 1'b1;
                        if (in_byte_ff == CH_QUOTE) begin
                           mode_in = MODE_QUOTED;
                        end else begin
                           mode_in = MODE_PLAIN;
                           recs[n] = make_rec(KIND_BYTE, in_byte_ff, token_idx(cnt_in),
                                              ERR_NONE, 1'b0);
                           n = n + 2'd1;
                        end
                     end
                  end
               end
            endcase
         end

         if (!ended && (in_byte_ff == CH_NUL || in_last_ff)) begin
            if (mode_in == MODE_PLAIN) begin
               recs[n] = make_rec(KIND_END, 8'd0, token_idx(cnt_in), ERR_NONE, 1'b0);
               n = n + 2'd1;
               recs[n] = make_rec(KIND_DONE, 8'd0, count_idx(cnt_in), ERR_NONE, 1'b1);
               n = n + 2'd1;
            end else if (mode_in == MODE_QUOTED || mode_in == MODE_EMBED) begin
               recs[n] = make_rec(KIND_ERROR, 8'd0, '0, ERR_UNTERM, 1'b1);
               n = n + 2'd1;
            end else if (cnt_in == '0) begin
               recs[n] = make_rec(KIND_ERROR, 8'd0, '0, ERR_EMPTY, 1'b1);
               n = n + 2'd1;
            end else begin
               recs[n] = make_rec(KIND_DONE, 8'd0, count_idx(cnt_in), ERR_NONE, 1'b1);
               n = n + 2'd1;
            end
            ended = 1'b1;
         end

         if (ended) begin
            if (in_last_ff) begin
               mode_in = MODE_BETWEEN;
               cnt_in  = '0;
            end else begin
               mode_in = MODE_DRAIN;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_BETWEEN;
         cnt_ff  <= '0;
      end else if (consume) begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign grp.valid = in_valid_ff;
   assign grp.count = n;
   assign grp.rec   = recs;

endmodule
`default_nettype wire

>>> src/clt_serializer.sv
// Result register for one group of records; hands out one per cycle unless stalled.
`default_nettype none
module clt_serializer (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire clt_pkg::grp_type grp,
   output logic                 grp_ready,
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   output clt_pkg::rec_type     rsp_rec
);
   import clt_pkg::*;

   logic                  valid_ff, valid_in;
   logic [1:0]            count_ff;
   logic [1:0]            pos_ff, pos_in;
   rec_type [REC_MAX-1:0] rec_ff;
   logic                  pop;
   logic                  last_pop;
   logic                  load;

   assign pop       = valid_ff && rsp_tready;
   assign last_pop  = pop && (pos_ff == count_ff - 2'd1);
   assign grp_ready = !valid_ff || last_pop;
   assign load      = grp.valid && grp_ready && (grp.count != 2'd0);

   always_comb begin
      valid_in = valid_ff;
      pos_in   = pos_ff;
      if (load) begin
         valid_in = 1'b1;
         pos_in   = 2'd0;
      end else if (last_pop) begin
         valid_in = 1'b0;
         pos_in   = 2'd0;
      end else if (pop) begin
         pos_in   = pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         count_ff <= grp.count;
         rec_ff   <= grp.rec;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_rec    = rec_ff[pos_ff];

endmodule
`default_nettype wire

>>> src/command_line_tokenizer_top.sv
// Top level of the command line tokenizer: streaming byte input, record output.
//
// The req_ channel carries one message byte per item; req_tlast marks the
// final byte of a message, and a zero byte ends the message early. The
// rsp_ channel carries one record per item: a token byte, a token end, the
// done record with the argument count, or an error record. rsp_tlast is set
// on the done or error record that closes a message.
// An accepted byte sits in the input register, where the mode machine decodes
// it into zero to three records; these go into the result register, which
// offers them on rsp_ in order. The first record of a byte is offered once
// the byte has passed the input register and the result register. The result
// register takes a new group as its last record is taken, so bytes flow on
// when the receiver keeps up. A byte that yields two or three records (the
// last byte of a plain token, for example) holds up the next byte, because the
// result register hands out one record per cycle while the receiver is ready.
// When the receiver stalls, the result register holds its record, the input
// register fills, and req_tready drops; nothing is lost or repeated.
// Bytes that follow a message record not closed by req_tlast are dropped up
// to and including the one marked req_tlast.
// Reset clears both registers, returns the scanner to the state between
// arguments and sets the argument count to zero.
`default_nettype none
module command_line_tokenizer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   input  wire logic        req_tlast,   // last_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] out_byte, [12:8] arg_index,
                                         // [14:13] error_code, [15] zero
   output logic [1:0]       rsp_tuser,   // [1:0] kind
   output logic             rsp_tlast    // message_end
);
   import clt_pkg::*;

   grp_type grp;
   logic    grp_ready;
   rec_type rsp_rec;

   clt_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .grp_ready  (grp_ready),
      .grp        (grp)
   );

   clt_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .grp        (grp),
      .grp_ready  (grp_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_rec    (rsp_rec)
   );

   // Records carry a zero byte and index wherever the record kind leaves them unused.
   assign rsp_tdata = {1'b0, rsp_rec.error_code, rsp_rec.arg_index, rsp_rec.out_byte};
   assign rsp_tuser = rsp_rec.kind;
   assign rsp_tlast = rsp_rec.message_end;

endmodule
`default_nettype wire

>>> src/clt_checker.sv
// Port-level checks for the command line tokenizer and their binding.
`default_nettype none
module clt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);
   import clt_pkg::*;

   // A stalled record holds still until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Only done and error records close a message.
   a_end_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == KIND_DONE || rsp_tuser == KIND_ERROR)))
      else $error("message end flag disagrees with record kind");

   // Error records always name a cause.
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_ERROR |-> rsp_tdata[14:13] != ERR_NONE)
      else $error("error record without a cause");

   // Quotes and zero bytes are consumed by the scanner, never passed on.
   a_tok_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_BYTE |->
         rsp_tdata[7:0] != CH_NUL && rsp_tdata[7:0] != CH_QUOTE)
      else $error("token byte is a quote or zero");

   // Nothing is offered in the cycle after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

endmodule

bind command_line_tokenizer_top clt_checker u_clt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

>>> verif/command_line_tokenizer_top_test.sv
// Self-checking testbench for the command line tokenizer: directed and random messages.
`default_nettype none
module command_line_tokenizer_top_test;
   import clt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // The longest correct quiet spell is a sender gap plus three records that each
   // wait out a receiver stall; this limit is far above that.
   localparam int STALL_LIMIT  = 400;
   localparam int TOTAL_BYTES  = 480;
   localparam int SHOWN_MAX    = 10;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   command_line_tokenizer_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Scanner state as this testbench tracks it, and the records still owed by the block.
   mode_type   scan_state;
   int         arg_total;
   rec_type    pending_records[$];
   logic [7:0] msg_bytes[$];

   // Each side idles at random only while its enable is set, so some stretches run
   // back to back at full rate.
   logic send_idle;
   logic recv_idle;

   int sent_bytes;
   int ignored_bytes;
   int messages_sent;
   int mismatch_count;
   int kind_seen[4];
   int error_seen[4];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Queues one expected record with the index trimmed to the port width.
   function automatic void push_record(input kind_type k, input logic [7:0] b,
                                       input logic [31:0] idx, input err_type e,
                                       input logic fin);
      rec_type r;
      r.kind        = k;
      r.out_byte    = b;
      r.arg_index   = idx[IDX_W-1:0];
      r.error_code  = e;
      r.message_end = fin;
      pending_records.push_back(r);
   endfunction

   // Number of the token that is currently open.
   function automatic int open_token();
      return (arg_total == 0) ? 0 : arg_total - 1;
   endfunction

   // Advances the tracked scanner by one accepted byte and queues the records it causes.
   function automatic void tokenize_byte(input logic [7:0] b, input logic fin);
      logic closed;
      closed = 1'b0;
      // After a message record that came without the last flag, bytes are dropped
      // up to and including the one that carries it.
      if (scan_state == MODE_DRAIN) begin
         ignored_bytes++;
         if (fin) begin
            scan_state = MODE_BETWEEN;
            arg_total  = 0;
         end
         return;
      end
      if (b != CH_NUL) begin
         case (scan_state)
            MODE_PLAIN: begin
               if (b == CH_SPACE) begin
                  push_record(KIND_END, CH_NUL, open_token(), ERR_NONE, 1'b0);
                  scan_state = MODE_BETWEEN;
               end else if (b == CH_QUOTE) begin
                  // The quote itself is dropped; everything up to the closing one is kept.
                  scan_state = MODE_EMBED;
               end else begin
                  push_record(KIND_BYTE, b, open_token(), ERR_NONE, 1'b0);
               end
            end
            MODE_QUOTED, MODE_EMBED: begin
               if (b == CH_QUOTE) begin
                  push_record(KIND_END, CH_NUL, open_token(), ERR_NONE, 1'b0);
                  scan_state = MODE_BETWEEN;
               end else begin
                  push_record(KIND_BYTE, b, open_token(), ERR_NONE, 1'b0);
               end
            end
            default: begin
               scan_state = MODE_BETWEEN;
               if (b != CH_SPACE) begin
                  if (arg_total >= MAX_ARGS) begin
                     push_record(KIND_ERROR, CH_NUL, 0, ERR_TOO_MANY, 1'b1);
                     closed = 1'b1;
                  end else begin
                     arg_total++;
                     if (b == CH_QUOTE) begin
                        scan_state = MODE_QUOTED;
                     end else begin
                        scan_state = MODE_PLAIN;
                        push_record(KIND_BYTE, b, open_token(), ERR_NONE, 1'b0);
                     end
                  end
               end
            end
         endcase
      end
      // A zero byte or the last flag closes the message once the byte itself is handled.
      if (!closed && (b == CH_NUL || fin)) begin
         if (scan_state == MODE_PLAIN) begin
            push_record(KIND_END, CH_NUL, open_token(), ERR_NONE, 1'b0);
            push_record(KIND_DONE, CH_NUL, arg_total, ERR_NONE, 1'b1);
         end else if (scan_state == MODE_QUOTED || scan_state == MODE_EMBED) begin
            push_record(KIND_ERROR, CH_NUL, 0, ERR_UNTERM, 1'b1);
         end else if (arg_total == 0) begin
            push_record(KIND_ERROR, CH_NUL, 0, ERR_EMPTY, 1'b1);
         end else begin
            push_record(KIND_DONE, CH_NUL, arg_total, ERR_NONE, 1'b1);
         end
         closed = 1'b1;
      end
      if (closed) begin
         if (fin) begin
            scan_state = MODE_BETWEEN;
            arg_total  = 0;
         end else begin
            scan_state = MODE_DRAIN;
         end
      end
   endfunction

   // Offers one byte, holds it until the block takes it, then predicts its records.
   // The valid is lowered only when a gap follows, so it never drops and rises in one step.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      int gap;
      gap = send_idle ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_bytes++;
      tokenize_byte(b, fin);
   endtask

   // Sends the assembled message with the last flag on its final byte.
   task automatic send_message();
      foreach (msg_bytes[i]) begin
         send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
      end
      msg_bytes.delete();
      messages_sent++;
   endtask

   // Any byte that is neither a space, a quote nor zero.
   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(1, 255));
      end while (b == CH_SPACE || b == CH_QUOTE);
      return b;
   endfunction

   // Content of a quoted stretch, where spaces are part of the token.
   function automatic logic [7:0] quoted_byte();
      return ($urandom_range(0, 3) == 0) ? CH_SPACE : text_byte();
   endfunction

   // Any byte at all, weighted toward the ones the scanner treats specially.
   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 7))
         0:       return CH_NUL;
         1, 2:    return CH_SPACE;
         3:       return CH_QUOTE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Style 0 is a plain token, 1 a quoted one, 2 a plain token with a quoted tail.
   function automatic void add_token(input int style);
      int len;
      len = $urandom_range(0, 4);
      case (style)
         0: begin
            msg_bytes.push_back(text_byte());
            repeat (len) msg_bytes.push_back(text_byte());
         end
         1: begin
            msg_bytes.push_back(CH_QUOTE);
            repeat (len) msg_bytes.push_back(quoted_byte());
            msg_bytes.push_back(CH_QUOTE);
         end
         default: begin
            msg_bytes.push_back(text_byte());
            msg_bytes.push_back(CH_QUOTE);
            repeat (len) msg_bytes.push_back(quoted_byte());
            msg_bytes.push_back(CH_QUOTE);
         end
      endcase
   endfunction

   // Builds a well-formed message of the given number of tokens with random content and
   // one of several endings: the last flag, an early zero with or without trailing
   // junk, or an open quote.
   function automatic void build_message(input int tokens);
      int   t;
      int   style;
      int   ending;
      logic quote_closed;
      quote_closed = 1'b0;
      repeat ($urandom_range(0, 2)) msg_bytes.push_back(CH_SPACE);
      for (t = 0; t < tokens; t++) begin
         // After a closing quote the next token may follow with no space at all.
         if (t > 0 && !(quote_closed && $urandom_range(0, 1) == 0))
            repeat ($urandom_range(1, 2)) msg_bytes.push_back(CH_SPACE);
         style = $urandom_range(0, 2);
         add_token(style);
         quote_closed = (style != 0);
      end
      ending = $urandom_range(0, 19);
      if (ending < 12) begin
         if ($urandom_range(0, 3) == 0) msg_bytes.push_back(CH_SPACE);
      end else if (ending < 15) begin
         msg_bytes.push_back(CH_NUL);
         repeat ($urandom_range(1, 3)) msg_bytes.push_back(noise_byte());
      end else if (ending < 17) begin
         msg_bytes.push_back(CH_NUL);
      end else begin
         if ($urandom_range(0, 1) == 0) msg_bytes.push_back(CH_SPACE);
         msg_bytes.push_back(CH_QUOTE);
         repeat ($urandom_range(0, 3)) msg_bytes.push_back(quoted_byte());
      end
      if (msg_bytes.size() == 0) msg_bytes.push_back(CH_SPACE);
   endfunction

   // Short hand-written messages: three records from one byte, quotes inside a plain
   // token, a token that starts right after a closing quote, an early zero in a quote
   // and in a plain token with the bytes after it dropped, empty messages and the
   // byte extremes.
   task automatic test_directed();
      send_idle = 1'b1;
      recv_idle = 1'b1;
      msg_bytes = '{CH_SPACE, "a", "b"};
      send_message();
      msg_bytes = '{"x", CH_QUOTE, "y", CH_SPACE, "z", CH_QUOTE, 8'hFF};
      send_message();
      msg_bytes = '{CH_QUOTE, 8'h01, CH_SPACE, CH_NUL, "q", "r"};
      send_message();
      msg_bytes = '{CH_NUL};
      send_message();
      msg_bytes = '{CH_SPACE, CH_SPACE};
      send_message();
      msg_bytes = '{CH_QUOTE};
      send_message();
      msg_bytes = '{"k", CH_SPACE};
      send_message();
      msg_bytes = '{"c", CH_NUL, "z"};
      send_message();
   endtask

   // Token counts around the limit; the token past the limit must raise the
   // too-many-arguments error before any of its bytes.
   task automatic test_arg_limit();
      int counts[4];
      counts = '{MAX_ARGS - 1, MAX_ARGS, MAX_ARGS + 1, MAX_ARGS + 3};
      foreach (counts[i]) begin
         send_idle = (i % 2 == 1);
         recv_idle = (i >= 2);
         build_message(counts[i]);
         send_message();
      end
   endtask

   // Mostly well-formed messages with random content, some near the argument limit,
   // and a share of pure noise, until the whole run has sent its planned byte count.
   task automatic test_random_messages();
      int pick;
      while (sent_bytes < TOTAL_BYTES) begin
         send_idle = ($urandom_range(0, 3) != 0);
         recv_idle = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 19);
         if (pick < 3) begin
            repeat ($urandom_range(1, 12)) msg_bytes.push_back(noise_byte());
         end else if (pick == 3) begin
            build_message($urandom_range(MAX_ARGS - 2, MAX_ARGS + 2));
         end else begin
            build_message($urandom_range(0, 6));
         end
         send_message();
      end
   endtask

   // Receiver: while its enable is set, idles for a random gap before each record, then takes it.
   initial begin : receiver
      int gap;
      forever begin
         gap = recv_idle ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // Compares each accepted record with the oldest one still expected. The outputs are
   // read right after the edge, before the block's updates for that edge land.
   always @(posedge clock) begin
      rec_type got;
      rec_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind        = kind_type'(rsp_tuser);
         got.out_byte    = rsp_tdata[7:0];
         got.arg_index   = rsp_tdata[12:8];
         got.error_code  = err_type'(rsp_tdata[14:13]);
         got.message_end = rsp_tlast;
         kind_seen[rsp_tuser]++;
         if (rsp_tuser == KIND_ERROR) error_seen[rsp_tdata[14:13]]++;
         if (pending_records.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= SHOWN_MAX)
               $display("%0t: unexpected record: kind %0d byte %02h index %0d err %0d end %0b",
                        $realtime, got.kind, got.out_byte, got.arg_index, got.error_code,
                        got.message_end);
         end else begin
            want = pending_records.pop_front();
            if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
                got.arg_index !== want.arg_index || got.error_code !== want.error_code ||
                got.message_end !== want.message_end || rsp_tdata[15] !== 1'b0) begin
               mismatch_count++;
               if (mismatch_count <= SHOWN_MAX) begin
                  $display("%0t: record mismatch (expected / actual)", $realtime);
                  $display("   kind %0d / %0d, byte %02h / %02h, index %0d / %0d",
                           want.kind, got.kind, want.out_byte, got.out_byte,
                           want.arg_index, got.arg_index);
                  $display("   error %0d / %0d, end %0b / %0b, pad bit 0 / %0b",
                           want.error_code, got.error_code, want.message_end,
                           got.message_end, rsp_tdata[15]);
               end
            end
         end
      end
   end

   // Watchdog: ends the run when no item moves on either side for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Timeout: no item moved for %0d cycles, %0d records still expected.",
               STALL_LIMIT, pending_records.size());
      $display("command_line_tokenizer_top verification failed");
      $finish;
   end

   // Main sequence: reset once, run the tests in turn, drain, then report.
   initial begin
      reset          <= 1'b1;
      req_tvalid     <= 1'b0;
      req_tdata      <= 8'h00;
      req_tlast      <= 1'b0;
      send_idle      = 1'b1;
      recv_idle      = 1'b1;
      scan_state     = MODE_BETWEEN;
      arg_total      = 0;
      sent_bytes     = 0;
      ignored_bytes  = 0;
      messages_sent  = 0;
      mismatch_count = 0;
      kind_seen      = '{0, 0, 0, 0};
      error_seen     = '{0, 0, 0, 0};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_arg_limit();
      test_random_messages();

      req_tvalid <= 1'b0;
      // The watchdog bounds this wait if records go missing.
      while (pending_records.size() != 0) @(posedge clock);
      // Waiting on past the drain catches any record the block emits beyond what was expected.
      repeat (8) @(posedge clock);
      if (pending_records.size() != 0) begin
         mismatch_count += pending_records.size();
         $display("%0d expected records never arrived.", pending_records.size());
      end

      $display("Ran %0d messages, %0d bytes (%0d dropped after an early end).",
               messages_sent, sent_bytes, ignored_bytes);
      $display("Records: %0d token bytes, %0d token ends, %0d done.",
               kind_seen[KIND_BYTE], kind_seen[KIND_END], kind_seen[KIND_DONE]);
      $display("Errors: %0d empty, %0d too many arguments, %0d unterminated; %0d mismatches.",
               error_seen[ERR_EMPTY], error_seen[ERR_TOO_MANY], error_seen[ERR_UNTERM],
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("command_line_tokenizer_top verification clean");
      end else begin
         $display("command_line_tokenizer_top verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> filelist.f
src/clt_pkg.sv
src/clt_core.sv
src/clt_serializer.sv
src/command_line_tokenizer_top.sv
src/clt_checker.sv
verif/command_line_tokenizer_top_test.sv
